[design/tbgd_pkg.sv]
// ----------------------------------------------------------------------------
// tbgd_pkg: shared types and constants for the three-body derivative block
// Word format, internal datapath widths and pipeline latencies.
// ----------------------------------------------------------------------------
package tbgd_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_BODIES = 3;

   // Magnitude of a coordinate difference, one bit wider than a word.
   localparam int DIFF_W = WORD_WIDTH + 1;
   // Sum of two squared differences.
   localparam int SUM_W  = 2 * DIFF_W;
   // Integer square root of that sum.
   localparam int ROOT_W = DIFF_W;
   // Cube of the root.
   localparam int CUBE_W = 3 * ROOT_W;
   // Numerator of the quotient: difference scaled by three fraction widths.
   localparam int NUM_W  = DIFF_W + 3 * FRAC_BITS;
   localparam int QUO_W  = WORD_WIDTH - 1;
   localparam int SHD_W  = CUBE_W + QUO_W;
   localparam int CMP_W  = (NUM_W > SHD_W) ? NUM_W : SHD_W;

   localparam int DIV_LAT   = QUO_W + 1;
   localparam int LANE_LAT  = ROOT_W + DIV_LAT + 7;
   localparam int TOTAL_LAT = LANE_LAT + 1;

   localparam int STATE_W = 2 * NUM_BODIES * WORD_WIDTH;
   localparam int TDATA_W = ((2 * STATE_W + 7) / 8) * 8;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type x;
      word_type y;
   } term_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

endpackage

[design/tbgd_div.sv]
// ----------------------------------------------------------------------------
// tbgd_div: pipelined restoring divider with saturation
// One quotient bit per stage; a quotient that would not fit in a word's
// magnitude is clamped to the largest magnitude.
// ----------------------------------------------------------------------------
module tbgd_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [tbgd_pkg::NUM_W-1:0]    num,
   input  logic [tbgd_pkg::CUBE_W-1:0]   den,
   output logic [tbgd_pkg::QUO_W-1:0]    mag
);
   import tbgd_pkg::*;

   logic [CMP_W-1:0]  n_ff     [QUO_W];
   logic [CUBE_W-1:0] d_ff     [QUO_W];
   logic [QUO_W-1:0]  q_ff     [QUO_W+1];
   logic              clamp_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]     <= CMP_W'(num);
         d_ff[0]     <= den;
         q_ff[0]     <= '0;
         clamp_ff[0] <= CMP_W'(num) >= (CMP_W'(den) << QUO_W);
      end
   end

   for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
      localparam int K = QUO_W - j;
      logic [CMP_W-1:0] shd;
      logic             take;

      always_comb begin
         shd  = CMP_W'(d_ff[j-1]) << K;
         take = n_ff[j-1] >= shd;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[j]     <= q_ff[j-1] | (QUO_W'(take) << K);
            clamp_ff[j] <= clamp_ff[j-1];
         end
      end

      if (j < QUO_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[j] <= take ? (n_ff[j-1] - shd) : n_ff[j-1];
               d_ff[j] <= d_ff[j-1];
            end
         end
      end
   end

   assign mag = clamp_ff[QUO_W] ? {QUO_W{1'b1}} : q_ff[QUO_W];

endmodule

[design/tbgd_lane.sv]
// ----------------------------------------------------------------------------
// tbgd_lane: pull of one body pair
// Difference, squared distance, bit-serial square root over stages, cube,
// and two dividers for the x and y terms of the lower-numbered body.
// ----------------------------------------------------------------------------
module tbgd_lane (
   input  logic                 clock,
   input  logic                 en,
   input  tbgd_pkg::word_type   pos_xi,
   input  tbgd_pkg::word_type   pos_yi,
   input  tbgd_pkg::word_type   pos_xj,
   input  tbgd_pkg::word_type   pos_yj,
   output tbgd_pkg::term_type   term
);
   import tbgd_pkg::*;

   localparam int SIDE_LEN = ROOT_W + 5;

   typedef struct packed {
      logic [DIFF_W-1:0] ax;
      logic [DIFF_W-1:0] ay;
      logic              nx;
      logic              ny;
   } side_type;

   typedef struct packed {
      logic nx;
      logic ny;
      logic coinc;
   } flag_type;

   logic signed [DIFF_W-1:0] dx, dy;
   side_type                 s1_in;
   side_type                 s1_ff;
   side_type                 side_ff [SIDE_LEN];
   logic [SUM_W-1:0]         sx_ff, sy_ff, s_ff;
   logic [SUM_W-1:0]         rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]        root_ff [ROOT_W];
   logic [2*ROOT_W-1:0]      r2_ff, plo_ff, phi_ff;
   logic [ROOT_W-1:0]        root_d_ff;
   logic [CUBE_W-1:0]        d_ff;
   flag_type                 flg_ff  [DIV_LAT];
   logic [QUO_W-1:0]         mag_x, mag_y;
   term_type                 term_in, term_ff;

   // Signed difference and its magnitude.
   always_comb begin
      dx = {pos_xj[WORD_WIDTH-1], pos_xj} - {pos_xi[WORD_WIDTH-1], pos_xi};
      dy = {pos_yj[WORD_WIDTH-1], pos_yj} - {pos_yi[WORD_WIDTH-1], pos_yi};
      s1_in.nx = dx[DIFF_W-1];
      s1_in.ny = dy[DIFF_W-1];
      s1_in.ax = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
      s1_in.ay = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= s1_in;
         side_ff[0] <= s1_ff;
         sx_ff      <= SUM_W'(s1_ff.ax) * SUM_W'(s1_ff.ax);
         sy_ff      <= SUM_W'(s1_ff.ay) * SUM_W'(s1_ff.ay);
         s_ff       <= sx_ff + sy_ff;
      end
   end

   for (genvar k = 1; k < SIDE_LEN; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Square root, one result bit per stage, keeping remainder = S - root^2.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int B = ROOT_W - 1 - k;
      logic [SUM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [SUM_W:0]    trial;
      logic              take;

      if (k == 0) begin : g_first
         assign rem_src  = s_ff;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      always_comb begin
         trial = ((SUM_W+1)'(root_src) << (B + 1)) + ((SUM_W+1)'(1) << (2 * B));
         take  = (SUM_W+1)'(rem_src) >= trial;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? SUM_W'((SUM_W+1)'(rem_src) - trial) : rem_src;
            root_ff[k] <= root_src | (ROOT_W'(take) << B);
         end
      end
   end

   // Cube of the root, the second product split into two halves.
   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff     <= (2*ROOT_W)'(root_ff[ROOT_W-1]) * (2*ROOT_W)'(root_ff[ROOT_W-1]);
         root_d_ff <= root_ff[ROOT_W-1];
         plo_ff    <= (2*ROOT_W)'(r2_ff[ROOT_W-1:0]) * (2*ROOT_W)'(root_d_ff);
         phi_ff    <= (2*ROOT_W)'(r2_ff[2*ROOT_W-1:ROOT_W]) * (2*ROOT_W)'(root_d_ff);
         d_ff      <= CUBE_W'(plo_ff) + (CUBE_W'(phi_ff) << ROOT_W);
      end
   end

   tbgd_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (NUM_W'(side_ff[SIDE_LEN-1].ax) << (3 * FRAC_BITS)),
      .den   (d_ff),
      .mag   (mag_x)
   );

   tbgd_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (NUM_W'(side_ff[SIDE_LEN-1].ay) << (3 * FRAC_BITS)),
      .den   (d_ff),
      .mag   (mag_y)
   );

   // A zero cube means the bodies coincide.
   always_ff @(posedge clock) begin
      if (en) begin
         flg_ff[0].nx    <= side_ff[SIDE_LEN-1].nx;
         flg_ff[0].ny    <= side_ff[SIDE_LEN-1].ny;
         flg_ff[0].coinc <= d_ff == '0;
      end
   end

   for (genvar k = 1; k < DIV_LAT; k++) begin : g_flag
      always_ff @(posedge clock) begin
         if (en) begin
            flg_ff[k] <= flg_ff[k-1];
         end
      end
   end

   always_comb begin
      if (flg_ff[DIV_LAT-1].coinc) begin
         term_in.x = WORD_MAX;
         term_in.y = WORD_MAX;
      end else begin
         term_in.x = flg_ff[DIV_LAT-1].nx ? -word_type'({1'b0, mag_x}) : word_type'({1'b0, mag_x});
         term_in.y = flg_ff[DIV_LAT-1].ny ? -word_type'({1'b0, mag_y}) : word_type'({1'b0, mag_y});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

[design/tbgd_merge.sv]
// ----------------------------------------------------------------------------
// tbgd_merge: per-body acceleration sums
// Adds each body's two pair terms with saturation to a word.
// ----------------------------------------------------------------------------
module tbgd_merge (
   input  logic                         clock,
   input  logic                         en,
   input  tbgd_pkg::term_type           t12,
   input  tbgd_pkg::term_type           t13,
   input  tbgd_pkg::term_type           t23,
   output logic [tbgd_pkg::STATE_W-1:0] acc
);
   import tbgd_pkg::*;

   word_type acc_in [2*NUM_BODIES];
   word_type acc_ff [2*NUM_BODIES];

   function automatic word_type sat_sum(input word_type a, input word_type b,
                                        input logic neg_a, input logic neg_b);
      logic signed [WORD_WIDTH+1:0] s;
      s = '0;
      s = neg_a ? s - (WORD_WIDTH+2)'(a) : s + (WORD_WIDTH+2)'(a);
      s = neg_b ? s - (WORD_WIDTH+2)'(b) : s + (WORD_WIDTH+2)'(b);
      if (s > (WORD_WIDTH+2)'(WORD_MAX)) begin
         return WORD_MAX;
      end else if (s < (WORD_WIDTH+2)'(WORD_MIN)) begin
         return WORD_MIN;
      end
      return word_type'(s);
   endfunction

   always_comb begin
      acc_in[0] = sat_sum(t12.x, t13.x, 1'b0, 1'b0);
      acc_in[1] = sat_sum(t12.y, t13.y, 1'b0, 1'b0);
      acc_in[2] = sat_sum(t12.x, t23.x, 1'b1, 1'b0);
      acc_in[3] = sat_sum(t12.y, t23.y, 1'b1, 1'b0);
      acc_in[4] = sat_sum(t13.x, t23.x, 1'b1, 1'b1);
      acc_in[5] = sat_sum(t13.y, t23.y, 1'b1, 1'b1);
   end

   for (genvar k = 0; k < 2*NUM_BODIES; k++) begin : g_acc
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in[k];
         end
      end
      assign acc[k*WORD_WIDTH +: WORD_WIDTH] = acc_ff[k];
   end

endmodule

[design/three_body_gravity_derivative.sv]
// ----------------------------------------------------------------------------
// three_body_gravity_derivative: planar three-body time derivative
// Accelerations of three unit-mass bodies and their passed-through velocities.
// ----------------------------------------------------------------------------
// One beat on the req_ channel carries a full state: six velocity words and
// six position words, signed Q16.16. One beat on the rsp_ channel returns the
// derivative: six accelerations, then the six velocities unchanged.
// The block is a fixed-length pipeline of TOTAL_LAT stages. A new beat can
// enter every cycle unless a result beat waits untaken. The pipeline depth
// is set by the square root, which produces one root bit per stage, and by
// the two dividers of each pair, which produce one quotient bit per stage.
// Three pair lanes (bodies 1-2, 1-3, 2-3) run side by side and a merge stage
// sums each body's two terms with saturation.
// When the result register holds a beat that is not taken, the whole pipeline
// holds and req_tready drops; it rises again in the cycle the beat is taken.
// Reset clears only the valid bits, so no result comes out until new beats
// are accepted.
// ----------------------------------------------------------------------------
module three_body_gravity_derivative (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // vel_x1, vel_y1, vel_x2, vel_y2, vel_x3, vel_y3,
   // pos_x1, pos_y1, pos_x2, pos_y2, pos_x3, pos_y3 (32 bits each)
   input  logic [tbgd_pkg::TDATA_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // acc_x1, acc_y1, acc_x2, acc_y2, acc_x3, acc_y3,
   // dpos_x1, dpos_y1, dpos_x2, dpos_y2, dpos_x3, dpos_y3 (32 bits each)
   output logic [tbgd_pkg::TDATA_W-1:0] rsp_tdata
);
   import tbgd_pkg::*;

   logic               en;
   logic               vld_ff [TOTAL_LAT];
   logic [STATE_W-1:0] vel_ff [TOTAL_LAT];
   logic [STATE_W-1:0] acc;
   word_type           pos [2*NUM_BODIES];
   term_type           t12, t13, t23;

   // Everything moves unless a finished beat is waiting at the output.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   for (genvar k = 0; k < 2*NUM_BODIES; k++) begin : g_pos
      assign pos[k] = req_tdata[STATE_W + k*WORD_WIDTH +: WORD_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vel_ff[0] <= req_tdata[STATE_W-1:0];
      end
   end

   // Velocities ride alongside the lanes so they line up with the sums.
   for (genvar k = 1; k < TOTAL_LAT; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            vel_ff[k] <= vel_ff[k-1];
         end
      end
   end

   tbgd_lane u_lane_12 (
      .clock  (clock),
      .en     (en),
      .pos_xi (pos[0]),
      .pos_yi (pos[1]),
      .pos_xj (pos[2]),
      .pos_yj (pos[3]),
      .term   (t12)
   );

   tbgd_lane u_lane_13 (
      .clock  (clock),
      .en     (en),
      .pos_xi (pos[0]),
      .pos_yi (pos[1]),
      .pos_xj (pos[4]),
      .pos_yj (pos[5]),
      .term   (t13)
   );

   tbgd_lane u_lane_23 (
      .clock  (clock),
      .en     (en),
      .pos_xi (pos[2]),
      .pos_yi (pos[3]),
      .pos_xj (pos[4]),
      .pos_yj (pos[5]),
      .term   (t23)
   );

   tbgd_merge u_merge (
      .clock (clock),
      .en    (en),
      .t12   (t12),
      .t13   (t13),
      .t23   (t23),
      .acc   (acc)
   );

   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];
   assign rsp_tdata  = TDATA_W'({vel_ff[TOTAL_LAT-1], acc});

endmodule

[tb/sv/three_body_gravity_derivative_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_body_gravity_derivative_test: self-checking bench for the derivative
// Drives state beats through the stream ports and compares each result beat
// with an exact integer computation of the inverse-square accelerations.
// ----------------------------------------------------------------------------
module three_body_gravity_derivative_test;
   import tbgd_pkg::*;

   localparam int NWORD = 2 * 2 * NUM_BODIES;       // words in one beat
   localparam int RANDOM_ITEMS = 1535;
   localparam int PHASES = 4;

   typedef logic [TDATA_W-1:0] beat_type;

   // One row of the directed table: a state, and optionally the accelerations
   // typed in by hand when they can be read off without arithmetic.
   typedef struct {
      beat_type state;
      bit       typed;
      word_type acc[6];
   } stim_row_type;

   logic     clock;
   logic     reset;
   logic     req_tvalid;
   logic     req_tready;
   beat_type req_tdata;
   logic     rsp_tvalid;
   logic     rsp_tready;
   beat_type rsp_tdata;

   beat_type derivative_queue[$];   // derivatives still owed by the block
   int       mismatch_count = 0;
   int       send_idle_pct  = 0;    // chance that the sender idles in a cycle
   int       stall_pct      = 0;    // chance that the receiver stalls a cycle

   three_body_gravity_derivative dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Saturating add to the signed word range.
   function automatic longint sat_word(longint a, longint b);
      longint s;
      s = a + b;
      if (s > longint'(WORD_MAX)) return longint'(WORD_MAX);
      if (s < longint'(WORD_MIN)) return longint'(WORD_MIN);
      return s;
   endfunction

   // Exact derivative of one state. Each pair's distance is the floor of the
   // square root of the summed squared raw differences, the pull on each axis
   // is |d| * 2^(3F) / r^3 truncated and clamped below 2^(W-1), and the
   // lower-numbered body takes the term with the sign of d, the other body
   // its negation. Coincident bodies push with full magnitude on both axes.
   function automatic beat_type gravity_derivative(beat_type st);
      longint      acc[6];
      word_type    pi, pj;
      longint      delta[2];
      bit          neg[2];
      logic [191:0] mag[2];
      logic [191:0] sum, root, trial, cube, quo;
      longint      term[2];
      beat_type    res;
      for (int k = 0; k < 6; k++) acc[k] = 0;
      for (int i = 0; i < NUM_BODIES; i++) begin
         for (int j = i + 1; j < NUM_BODIES; j++) begin
            for (int a = 0; a < 2; a++) begin
               pi = st[(6 + 2 * i + a) * WORD_WIDTH +: WORD_WIDTH];
               pj = st[(6 + 2 * j + a) * WORD_WIDTH +: WORD_WIDTH];
               delta[a] = longint'(pj) - longint'(pi);
               neg[a]   = delta[a] < 0;
               mag[a]   = neg[a] ? -delta[a] : delta[a];
            end
            sum = mag[0] * mag[0] + mag[1] * mag[1];
            if (sum == 0) begin
               term[0] = longint'(WORD_MAX);
               term[1] = longint'(WORD_MAX);
            end else begin
               root = 0;
               for (int b = WORD_WIDTH + 2; b >= 0; b--) begin
                  trial = root | (192'd1 << b);
                  if (trial * trial <= sum) root = trial;
               end
               cube = root * root * root;
               for (int a = 0; a < 2; a++) begin
                  quo = (mag[a] << (3 * FRAC_BITS)) / cube;
                  if (quo > 192'(WORD_MAX)) quo = 192'(WORD_MAX);
                  term[a] = neg[a] ? -longint'(quo) : longint'(quo);
               end
            end
            for (int a = 0; a < 2; a++) begin
               acc[2 * i + a] = sat_word(acc[2 * i + a], term[a]);
               acc[2 * j + a] = sat_word(acc[2 * j + a], -term[a]);
            end
         end
      end
      for (int k = 0; k < 6; k++) begin
         res[k * WORD_WIDTH +: WORD_WIDTH]       = word_type'(acc[k]);
         res[(6 + k) * WORD_WIDTH +: WORD_WIDTH] = st[k * WORD_WIDTH +: WORD_WIDTH];
      end
      return res;
   endfunction

   // Packs velocities and positions into a request beat, first field lowest.
   function automatic beat_type pack_state(word_type vel[6], word_type pos[6]);
      beat_type st;
      st = '0;
      for (int k = 0; k < 6; k++) begin
         st[k * WORD_WIDTH +: WORD_WIDTH]       = vel[k];
         st[(6 + k) * WORD_WIDTH +: WORD_WIDTH] = pos[k];
      end
      return st;
   endfunction

   // A random offset of up to a random number of bits, so that bodies sit
   // anywhere from a raw step apart to across the whole range.
   function automatic word_type near_offset();
      int bits;
      bits = $urandom_range(WORD_WIDTH - 1);
      return $signed($urandom) >>> bits;
   endfunction

   // Random state. Most states keep the bodies close enough that the pulls
   // land inside the word range; the rest are wide apart, coincident or
   // aligned on one axis.
   function automatic beat_type random_state();
      word_type vel[6], pos[6];
      word_type cx, cy;
      int       shape, p, q, ax;
      for (int k = 0; k < 6; k++) vel[k] = $urandom;
      shape = $urandom_range(9);
      cx = $urandom;
      cy = $urandom;
      for (int b = 0; b < NUM_BODIES; b++) begin
         if (shape == 0) begin
            pos[2 * b]     = $urandom;
            pos[2 * b + 1] = $urandom;
         end else begin
            pos[2 * b]     = cx + near_offset();
            pos[2 * b + 1] = cy + near_offset();
         end
      end
      p = $urandom_range(NUM_BODIES - 1);
      q = (p + 1 + $urandom_range(1)) % NUM_BODIES;
      if (shape == 1) begin
         pos[2 * q]     = pos[2 * p];
         pos[2 * q + 1] = pos[2 * p + 1];
      end else if (shape == 2) begin
         ax = $urandom_range(1);
         pos[2 * q + ax] = pos[2 * p + ax];
      end else if (shape == 3) begin
         pos[2 * q + 1] = pos[2 * p + 1];
      end
      return pack_state(vel, pos);
   endfunction

   // Receiver: takes result beats and checks each against the oldest
   // expectation. Ready is rerolled every cycle.
   always @(posedge clock) begin
      beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (derivative_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat %h", rsp_tdata);
            end else begin
               want = derivative_queue.pop_front();
               for (int k = 0; k < NWORD; k++) begin
                  if (rsp_tdata[k * WORD_WIDTH +: WORD_WIDTH] !==
                      want[k * WORD_WIDTH +: WORD_WIDTH]) begin
                     mismatch_count++;
                     if (mismatch_count <= 10)
                        $display("result word %0d: expected %h, got %h", k,
                                 want[k * WORD_WIDTH +: WORD_WIDTH],
                                 rsp_tdata[k * WORD_WIDTH +: WORD_WIDTH]);
                  end
               end
            end
         end
      end
   end

   // Sends one state beat, idling first at the current rate, and records
   // what the block owes for it once the beat is taken.
   task automatic send_state(beat_type st, beat_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= beat_type'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= st;
      do @(posedge clock); while (!req_tready);
      derivative_queue.push_back(want);
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      word_type     vmix[6], vzero[6];
      word_type     sat_acc[6];
      beat_type     want;
      int           settle;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;

      vmix  = '{WORD_MIN, WORD_MAX, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0};
      vzero = '{default: 0};
      // All three bodies on one spot: body 1 is pushed to the top twice and
      // saturates, body 2's two pushes cancel, body 3 saturates at the bottom.
      sat_acc = '{WORD_MAX, WORD_MAX, 0, 0, WORD_MIN, WORD_MIN};

      row.typed = 1'b1;
      row.acc   = sat_acc;
      row.state = pack_state(vmix, '{default: 0});
      rows.push_back(row);
      row.state = pack_state(vzero, '{default: WORD_MAX});
      rows.push_back(row);
      row.state = pack_state('{default: WORD_MIN}, '{default: WORD_MIN});
      rows.push_back(row);

      row.typed = 1'b0;
      // Unit triangle, raw-step neighbors where the pull clamps, one axis
      // shared, far extremes, a coincident pair beside a distant body.
      row.state = pack_state(vmix, '{0, 0, 32'h10000, 0, 0, 32'h10000});
      rows.push_back(row);
      row.state = pack_state(vzero, '{0, 0, 1, 0, 0, 1});
      rows.push_back(row);
      row.state = pack_state(vmix, '{0, 0, 0, 32'h20000, 32'h30000, 0});
      rows.push_back(row);
      row.state = pack_state(vmix, '{WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, 0, 0});
      rows.push_back(row);
      row.state = pack_state(vzero, '{WORD_MIN, 0, WORD_MAX, 0, 0, WORD_MAX});
      rows.push_back(row);
      row.state = pack_state(vmix, '{32'h50000, 32'h50000, 32'h50000, 32'h50000, 0, 0});
      rows.push_back(row);
      row.state = pack_state(vmix, '{0, 0, 32'h10000, 32'h10000, 0, 0});
      rows.push_back(row);
      row.state = pack_state(vzero, '{32'h10000, -32'sh20000, -32'sh30000, 32'h40000,
                                      32'h70000, 32'h10000});
      rows.push_back(row);
      row.state = pack_state(vmix, '{0, 0, 1, 1, 1, 0});
      rows.push_back(row);
      row.state = pack_state(vmix, '{-32'sh1, -32'sh1, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN});
      rows.push_back(row);
      row.state = pack_state(vzero, '{32'h100, 32'h0, 32'h0, 32'h100, -32'sh100, -32'sh100});
      rows.push_back(row);
      row.state = pack_state(vmix, '{0, 0, 32'h4000_0000, 0, 0, -32'sh4000_0000});
      rows.push_back(row);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at full rate on both sides.
      foreach (rows[n]) begin
         if (rows[n].typed) begin
            want = gravity_derivative(rows[n].state);
            for (int k = 0; k < 6; k++)
               want[k * WORD_WIDTH +: WORD_WIDTH] = rows[n].acc[k];
         end else begin
            want = gravity_derivative(rows[n].state);
         end
         send_state(rows[n].state, want);
      end

      // Random states in four idling phases: none, sender idle, receiver
      // stalling, both.
      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct = (ph == 1) ? 82 : (ph == 3) ? 27 : 0;
         stall_pct     = (ph == 2) ? 82 : (ph == 3) ? 27 : 0;
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            row.state = random_state();
            send_state(row.state, gravity_derivative(row.state));
         end
      end
      req_tvalid <= 1'b0;

      while (derivative_queue.size() != 0) @(posedge clock);
      settle = 0;
      while (settle < 2 * TOTAL_LAT) begin
         @(posedge clock);
         settle++;
      end

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[three_body_gravity_derivative.f]
design/tbgd_pkg.sv
design/tbgd_div.sv
design/tbgd_lane.sv
design/tbgd_merge.sv
design/three_body_gravity_derivative.sv
tb/sv/three_body_gravity_derivative_test.sv
